### sv/ffa_pkg.sv
// Shared types and constants of the first-fit free-list allocator.
package ffa_pkg;

  localparam int ListEntries = 256;
  localparam int AddrBits    = 32;
  localparam int LenBits     = 32;
  localparam int IdxBits     = $clog2(ListEntries);
  localparam int CntBits     = $clog2(ListEntries + 1);

  // One free region as it travels along the chain
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [LenBits-1:0]  len;
  } entry_t;

  // Result word handed from the controller to the ports
  typedef struct packed {
    logic [AddrBits-1:0] granted;
    logic                ok;
    logic [31:0]         free_total;
    logic [31:0]         lost_count;
    logic [31:0]         lost_bytes;
  } result_t;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

endpackage

### sv/ffa_cell.sv
// One storage cell of the entry chain: holds a region, passes it on when shifted.
module ffa_cell import ffa_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t d_i,
  output entry_t q_o
);

  entry_t entry_q;

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

### sv/ffa_ctrl.sv
// Head-of-chain controller: edits the region stream during one full rotation.
module ffa_ctrl import ffa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                op_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [LenBits-1:0]  len_i,
  output logic                busy_o,
  output logic                shift_o,
  input  entry_t              c0_i,
  input  entry_t              c1_i,
  output entry_t              tail_o,
  output logic                valid_o,
  output result_t             res_o
);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;
  typedef enum logic [1:0] {MODE_PASS, MODE_REMOVE, MODE_HOLD} mode_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [IdxBits-1:0]  k_q, k_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                op_q, op_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [AddrBits-1:0] end_q, end_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic                at_pos_q, at_pos_d;
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic [AddrBits-1:0] granted_q, granted_d;
  entry_t              hold_q, hold_d;
  logic [31:0]         free_q, free_d;
  logic [31:0]         lostc_q, lostc_d;
  logic [31:0]         lostb_q, lostb_d;
  logic                valid_q, valid_d;
  result_t             res_q, res_d;

  logic                accept, last, v0, v1, le0, le1, at_pos;
  logic [CntBits-1:0]  k_ext, k_nxt;
  logic [AddrBits-1:0] prev_end;
  entry_t              tail;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign last     = (k_q == IdxBits'(ListEntries - 1));
  assign k_ext    = CntBits'(k_q);
  assign k_nxt    = k_ext + CntBits'(1);
  // slot validity follows from the fill count: live entries lead the stream
  assign v0       = k_ext < cnt_q;
  assign v1       = (k_nxt < cnt_q) && !last;
  assign le0      = v0 && (c0_i.start <= addr_q);
  assign le1      = v1 && (c1_i.start <= addr_q);
  assign prev_end = AddrBits'(c0_i.start + AddrBits'(c0_i.len));
  assign at_pos   = at_pos_q || ((k_q == '0) && !le0);

  // stream editing for the current slot
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    addr_d    = addr_q;
    end_d     = end_q;
    len_d     = len_q;
    at_pos_d  = at_pos_q;
    done_d    = done_q;
    ok_d      = ok_q;
    granted_d = granted_q;
    hold_d    = hold_q;
    free_d    = free_q;
    lostc_d   = lostc_q;
    lostb_d   = lostb_q;
    valid_d   = 1'b0;
    res_d     = res_q;

    unique case (mode_q)
      MODE_REMOVE: tail = c1_i;
      MODE_HOLD: begin
        tail   = hold_q;
        hold_d = c0_i;
      end
      default: tail = c0_i;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_RUN;
          mode_d    = MODE_PASS;
          k_d       = '0;
          op_d      = op_i;
          addr_d    = addr_i;
          len_d     = len_i;
          end_d     = AddrBits'(addr_i + AddrBits'(len_i));
          at_pos_d  = 1'b0;
          done_d    = 1'b0;
          ok_d      = 1'b0;
          granted_d = '0;
        end
      end
      ST_RUN: begin
        k_d = k_q + IdxBits'(1);
        if (!done_q && (mode_q == MODE_PASS)) begin
          if (op_q == OpAlloc) begin
            // first fit
            if (v0 && (c0_i.len >= len_q)) begin
              done_d    = 1'b1;
              ok_d      = 1'b1;
              granted_d = c0_i.start;
              if (c0_i.len == len_q) begin
                tail   = c1_i;
                mode_d = MODE_REMOVE;
                cnt_d  = cnt_q - CntBits'(1);
              end else begin
                tail.start = AddrBits'(c0_i.start + AddrBits'(len_q));
                tail.len   = c0_i.len - len_q;
              end
            end
          end else if (at_pos) begin
            // sorted place reached, no merge with the region before
            done_d = 1'b1;
            if (v0 && (end_q == c0_i.start)) begin
              ok_d       = 1'b1;
              tail.start = addr_q;
              tail.len   = c0_i.len + len_q;
            end else if (cnt_q < CntBits'(ListEntries)) begin
              ok_d       = 1'b1;
              tail.start = addr_q;
              tail.len   = len_q;
              hold_d     = c0_i;
              mode_d     = MODE_HOLD;
              cnt_d      = cnt_q + CntBits'(1);
            end
          end else if (le0 && !le1) begin
            // region just before the sorted place
            if (prev_end == addr_q) begin
              done_d = 1'b1;
              ok_d   = 1'b1;
              tail.start = c0_i.start;
              if (v1 && (end_q == c1_i.start)) begin
                tail.len = c0_i.len + len_q + c1_i.len;
                mode_d   = MODE_REMOVE;
                cnt_d    = cnt_q - CntBits'(1);
              end else begin
                tail.len = c0_i.len + len_q;
              end
            end else begin
              at_pos_d = 1'b1;
            end
          end
        end
        // end of rotation: settle totals and present the result
        if (last) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          if (ok_d) begin
            free_d = (op_q == OpFree) ? free_q + len_q : free_q - len_q;
          end else if (op_q == OpFree) begin
            lostc_d = lostc_q + 32'd1;
            lostb_d = lostb_q + len_q;
          end
          res_d.granted    = granted_d;
          res_d.ok         = ok_d;
          res_d.free_total = free_d;
          res_d.lost_count = lostc_d;
          res_d.lost_bytes = lostb_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= MODE_PASS;
      k_q      <= '0;
      cnt_q    <= '0;
      at_pos_q <= 1'b0;
      done_q   <= 1'b0;
      free_q   <= '0;
      lostc_q  <= '0;
      lostb_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      at_pos_q <= at_pos_d;
      done_q   <= done_d;
      free_q   <= free_d;
      lostc_q  <= lostc_d;
      lostb_q  <= lostb_d;
      valid_q  <= valid_d;
    end
  end

  // word registers, no reset
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    addr_q    <= addr_d;
    end_q     <= end_d;
    len_q     <= len_d;
    ok_q      <= ok_d;
    granted_q <= granted_d;
    hold_q    <= hold_d;
    res_q     <= res_d;
  end

  assign busy_o  = (state_q == ST_RUN);
  assign shift_o = (state_q == ST_RUN);
  assign tail_o  = tail;
  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(ListEntries)) else $error("fill count beyond list depth");
  a_valid_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_RUN)) else $error("result without a rotation");
  a_hold_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HOLD) |-> (op_q == OpFree)) else $error("insert during allocate");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted word not in progress");
`endif

endmodule

### sv/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator: chain of cells and its controller.
//
//  channel  | handshake           | words
//  ---------+---------------------+--------------------------------------------
//  request  | start_i / busy_o    | operation_i, region_start_i, region_length_i
//  result   | valid_o (strobe)    | granted_start_o, ok_o, free_total_o,
//           |                     | lost_count_o, lost_bytes_o
//
// Every request takes one full rotation of the cell chain (one entry past the
// controller per cycle); the result strobes in the cycle after the rotation ends.
// A new request may be taken in the strobe cycle. Reset clears the fill count
// and the loss counters; cell contents are unset and never read before written.
// The receiver cannot stall: valid_o is high for a single cycle per result.
module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                operation_i,
  input  logic [AddrBits-1:0] region_start_i,
  input  logic [LenBits-1:0]  region_length_i,
  output logic                valid_o,
  output logic [AddrBits-1:0] granted_start_o,
  output logic                ok_o,
  output logic [31:0]         free_total_o,
  output logic [31:0]         lost_count_o,
  output logic [31:0]         lost_bytes_o
);

  entry_t  chain_q [ListEntries];
  entry_t  tail;
  logic    shift;
  result_t res;

  // ring of cells, each taking its neighbour's entry on every shift; the last takes the controller's tail
  for (genvar i = 0; i < ListEntries; i++) begin : gen_cell
    if (i == ListEntries - 1) begin : gen_tail
      ffa_cell u_cell (.clk_i(clk_i), .shift_i(shift), .d_i(tail), .q_o(chain_q[i]));
    end else begin : gen_mid
      ffa_cell u_cell (.clk_i(clk_i), .shift_i(shift), .d_i(chain_q[i+1]),
                       .q_o(chain_q[i]));
    end
  end

  ffa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (operation_i),
    .addr_i  (region_start_i),
    .len_i   (region_length_i),
    .busy_o  (busy_o),
    .shift_o (shift),
    .c0_i    (chain_q[0]),
    .c1_i    (chain_q[1]),
    .tail_o  (tail),
    .valid_o (valid_o),
    .res_o   (res)
  );

  assign granted_start_o = res.granted;
  assign ok_o            = res.ok;
  assign free_total_o    = res.free_total;
  assign lost_count_o    = res.lost_count;
  assign lost_bytes_o    = res.lost_bytes;

endmodule

### tb/tb_first_fit_free_list_allocator.sv
// Testbench of the first-fit free-list allocator: directed, fill and random requests.
`timescale 1ns / 100ps

// Expected result word of one request
typedef struct {
  logic [31:0] granted;
  logic        ok;
  logic [31:0] free_total;
  logic [31:0] lost_count;
  logic [31:0] lost_bytes;
} alloc_word_t;

// Free-list predictor and store of expected words
class alloc_scoreboard;
  logic [31:0] reg_start [ffa_pkg::ListEntries];
  logic [31:0] reg_len   [ffa_pkg::ListEntries];
  int          fill;
  logic [31:0] lost_n;
  logic [31:0] lost_b;
  alloc_word_t due_q[$];
  int          errors;

  function new();
    fill   = 0;
    lost_n = '0;
    lost_b = '0;
    errors = 0;
  endfunction

  function void drop_at(int at);
    for (int j = at + 1; j < fill; j++) begin
      reg_start[j-1] = reg_start[j];
      reg_len[j-1]   = reg_len[j];
    end
    fill--;
  endfunction

  // Predict the word of one accepted request
  function void note(logic op, logic [31:0] addr, logic [31:0] len);
    alloc_word_t w;
    int          pos;
    logic        prev_ok, next_ok;
    w.granted = '0;
    w.ok      = 1'b0;
    if (op == ffa_pkg::OpAlloc) begin
      for (int k = 0; k < fill; k++) begin
        if (reg_len[k] >= len) begin
          w.granted    = reg_start[k];
          w.ok         = 1'b1;
          reg_len[k]   = reg_len[k] - len;
          reg_start[k] = reg_start[k] + len;
          if (reg_len[k] == 0) drop_at(k);
          break;
        end
      end
    end else begin
      pos = 0;
      while (pos < fill && reg_start[pos] <= addr) pos++;
      prev_ok = pos > 0;
      next_ok = pos < fill;
      w.ok = 1'b1;
      if (prev_ok && reg_start[pos-1] + reg_len[pos-1] == addr) begin
        reg_len[pos-1] = reg_len[pos-1] + len;
        // double merge: absorb the following region
        if (next_ok && reg_start[pos-1] + reg_len[pos-1] == reg_start[pos]) begin
          reg_len[pos-1] = reg_len[pos-1] + reg_len[pos];
          drop_at(pos);
        end
      end else if (next_ok && addr + len == reg_start[pos]) begin
        reg_start[pos] = addr;
        reg_len[pos]   = reg_len[pos] + len;
      end else if (fill < ffa_pkg::ListEntries) begin
        for (int j = fill; j > pos; j--) begin
          reg_start[j] = reg_start[j-1];
          reg_len[j]   = reg_len[j-1];
        end
        reg_start[pos] = addr;
        reg_len[pos]   = len;
        fill++;
      end else begin
        w.ok   = 1'b0;
        lost_n = lost_n + 1;
        lost_b = lost_b + len;
      end
    end
    w.free_total = '0;
    for (int k = 0; k < fill; k++) w.free_total = w.free_total + reg_len[k];
    w.lost_count = lost_n;
    w.lost_bytes = lost_b;
    due_q.push_back(w);
  endfunction

  function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare one strobed word with the oldest expectation
  function void check(alloc_word_t a);
    alloc_word_t e;
    if (due_q.size() == 0) begin
      $display("%0t: unexpected word, expected none actual %h", $time, a.granted);
      errors++;
      return;
    end
    e = due_q.pop_front();
    field("granted_start", e.granted, a.granted);
    field("ok", {31'b0, e.ok}, {31'b0, a.ok});
    field("free_total", e.free_total, a.free_total);
    field("lost_count", e.lost_count, a.lost_count);
    field("lost_bytes", e.lost_bytes, a.lost_bytes);
  endfunction
endclass

module tb_first_fit_free_list_allocator;
  import ffa_pkg::*;

  localparam int CycleLimit = 2000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                operation_i = OpAlloc;
  logic [AddrBits-1:0] region_start_i = '0;
  logic [LenBits-1:0]  region_length_i = '0;
  logic                valid_o;
  logic [AddrBits-1:0] granted_start_o;
  logic                ok_o;
  logic [31:0]         free_total_o;
  logic [31:0]         lost_count_o;
  logic [31:0]         lost_bytes_o;

  alloc_scoreboard sb = new();
  int              cycles = 0;
  int              idle_pct = 0;

  first_fit_free_list_allocator DUT (.*);

  always #5 clk_i = ~clk_i;

  // Result monitor and run limit
  always @(posedge clk_i) begin
    alloc_word_t a;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && valid_o) begin
      a.granted    = granted_start_o;
      a.ok         = ok_o;
      a.free_total = free_total_o;
      a.lost_count = lost_count_o;
      a.lost_bytes = lost_bytes_o;
      sb.check(a);
    end
  end

  // Present one request word and hold it until taken; then maybe idle
  // (the gap may end before, at or after the end of the rotation)
  task automatic send_word(logic op, logic [31:0] addr, logic [31:0] len);
    start_i         <= 1'b1;
    operation_i     <= op;
    region_start_i  <= addr;
    region_length_i <= len;
    do @(posedge clk_i); while (busy_o);
    sb.note(op, addr, len);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 2 * ListEntries)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int          pick;
    logic [31:0] a, l;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, merges both ways, equal start, zero lengths, wrap
    send_word(OpAlloc, 32'h0, 32'h10);
    send_word(OpAlloc, 32'hFFFFFFFF, 32'h0);
    send_word(OpFree, 32'h100, 32'h10);
    send_word(OpFree, 32'h200, 32'h10);
    send_word(OpFree, 32'h110, 32'hF0);
    send_word(OpFree, 32'h80, 32'h80);
    send_word(OpFree, 32'h80, 32'h0);
    send_word(OpAlloc, 32'h0, 32'h0);
    send_word(OpAlloc, 32'h0, 32'h10);
    send_word(OpAlloc, 32'h0, 32'hFFFFFFFF);
    send_word(OpFree, 32'hFFFFFFF0, 32'h20);
    send_word(OpFree, 32'h10, 32'h5);
    send_word(OpFree, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(OpAlloc, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(OpAlloc, 32'h0, 32'h5);
    send_word(OpAlloc, 32'h0, 32'h170);
    send_word(OpFree, 32'h0, 32'h0);
    send_word(OpAlloc, 32'h0, 32'h1);
    drain();

    // Fill the list with separate regions until words get dropped
    idle_pct = 20;
    for (int k = 0; k < 262; k++)
      send_word(OpFree, 32'h1000_0000 + k * 64, 32'h10 + $urandom_range(0, 3));
    drain();

    // Random mix, idling phases by item index
    for (int i = 0; i < 120; i++) begin
      case ((i / 30) % 4)
        0: idle_pct = 0;
        1: idle_pct = 86;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_word(OpAlloc, $urandom, $urandom_range(0, 64));
      end else if (pick < 88) begin
        a = 32'h1000_0000 + $urandom_range(0, 1023) * 16;
        l = ($urandom_range(1)) ? 32'h10 : $urandom_range(0, 48);
        send_word(OpFree, a, l);
      end else begin
        send_word(1'($urandom_range(1)), $urandom, $urandom);
      end
    end
    drain();
    repeat (300) @(posedge clk_i);

    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### first_fit_free_list_allocator.f
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_ctrl.sv
sv/first_fit_free_list_allocator.sv
tb/tb_first_fit_free_list_allocator.sv
